// File: rtl/spring_distance_constraint_macros.svh
// assertion helpers for the spring distance constraint block
`ifndef SPRING_DISTANCE_CONSTRAINT_MACROS_SVH
`define SPRING_DISTANCE_CONSTRAINT_MACROS_SVH

`ifndef ASSERT_OFF
`define SDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdc check failed");
`define SDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdc check failed");
`else
`define SDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/sdc_pkg.sv
package sdc_pkg;

    localparam int unsigned COORD_W     = 32;
    localparam int unsigned REST_W      = 31;
    localparam int unsigned STIFF_W     = 17;
    localparam int unsigned MIN_W       = 16;
    localparam int unsigned LEN_W       = 33;
    localparam int unsigned RAD_W       = 66;
    localparam int unsigned REM_W       = 35;
    localparam int unsigned NUM_W       = 66;
    localparam int unsigned PROD_W      = 50;
    localparam int unsigned SUM_W       = 36;
    localparam int unsigned FRAC_W      = 16;
    // stiffness is Q1.16 and the correction is halved
    localparam int unsigned STIFF_SHIFT = 17;
    localparam int unsigned SQ_STEPS    = RAD_W / 2;
    localparam int unsigned DV_STEPS    = LEN_W;
    localparam logic [MIN_W-1:0] MIN_DIST_RESET = 16'd3;

    typedef struct packed {
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
        logic [REST_W-1:0]  rest_length;
        logic [STIFF_W-1:0] stiffness;
    } spring_t;

    typedef struct packed {
        logic [COORD_W-1:0] new_first_x;
        logic [COORD_W-1:0] new_first_y;
        logic [COORD_W-1:0] new_second_x;
        logic [COORD_W-1:0] new_second_y;
    } result_t;

    typedef logic [MIN_W-1:0] min_dist_t;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [LEN_W-1:0] root;
    } sqs_t;

    typedef struct packed {
        logic [LEN_W-1:0] rem;
        logic [LEN_W-1:0] num_lo;
        logic [LEN_W-1:0] quot;
    } dvs_t;

    function automatic logic [COORD_W-1:0] sat32(input logic [SUM_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v[SUM_W-1:COORD_W-1] == '0 || v[SUM_W-1:COORD_W-1] == '1)
            r = v[COORD_W-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = {1'b0, {(COORD_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// File: rtl/sdc_stream_if.sv
interface sdc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sdc_sqrt_cell.sv
module sdc_sqrt_cell (
    input  logic          clk,
    input  logic          en,
    input  sdc_pkg::sqs_t cur,
    output sdc_pkg::sqs_t nxt
);
    import sdc_pkg::*;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             fits;
    sqs_t             step;

    // one root bit per cell, two radicand bits brought down
    always_comb
    begin
        rem_sh    = {cur.rem, cur.rad[RAD_W-1 -: 2]};
        trial     = (REM_W+2)'({cur.root, 2'b01});
        fits      = rem_sh >= trial;
        step.rad  = {cur.rad[RAD_W-3:0], 2'b00};
        step.root = {cur.root[LEN_W-2:0], fits};
        step.rem  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt <= step;
        end
    end
endmodule

// File: rtl/sdc_div_cell.sv
module sdc_div_cell (
    input  logic                      clk,
    input  logic                      en,
    input  sdc_pkg::dvs_t             cur,
    input  logic [sdc_pkg::LEN_W-1:0] divisor,
    output sdc_pkg::dvs_t             nxt
);
    import sdc_pkg::*;

    logic [LEN_W:0] rem_sh;
    logic [LEN_W:0] dvs_ext;
    logic           fits;
    dvs_t           step;

    // one quotient bit per cell, restoring
    always_comb
    begin
        rem_sh      = {cur.rem, cur.num_lo[LEN_W-1]};
        dvs_ext     = {1'b0, divisor};
        fits        = rem_sh >= dvs_ext;
        step.num_lo = {cur.num_lo[LEN_W-2:0], 1'b0};
        step.quot   = {cur.quot[LEN_W-2:0], fits};
        step.rem    = fits ? LEN_W'(rem_sh - dvs_ext) : LEN_W'(rem_sh);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt <= step;
        end
    end
endmodule

// File: rtl/spring_distance_constraint.sv
// One spring relaxation per clock: the block takes a new spring beat every cycle unless
// the row is held. Its path runs through two rows of
// cells, a 33-cell square root (one length bit per cell) and a 33-cell divider (one
// quotient bit per cell, x and y side by side), plus seven stages of squaring,
// products, stiffness scaling and the output register. While a result waits, the row
// keeps moving while its last stage is empty; a spring waiting there holds the whole row.
// min_distance resets to 3 and may be written while no spring is in flight.
`include "spring_distance_constraint_macros.svh"

module spring_distance_constraint (
    input  logic        clk,
    input  logic        rst_n,
    sdc_stream_if.sink   spring,
    sdc_stream_if.source result,
    sdc_stream_if.sink   cfg
);
    import sdc_pkg::*;

    localparam int unsigned NV     = 6 + SQ_STEPS + DV_STEPS;
    localparam int unsigned V_OFF  = 3 + SQ_STEPS;
    localparam int unsigned V_MUL  = NV - 1;

    typedef struct packed {
        spring_t              pts;
        logic [LEN_W-1:0]     len;
        logic [LEN_W-1:0]     offm;
        logic                 off_neg;
        logic [COORD_W-1:0]   dxm;
        logic [COORD_W-1:0]   dym;
        logic                 dx_neg;
        logic                 dy_neg;
        logic                 norm;
    } off_t;

    typedef struct packed {
        spring_t              pts;
        logic [LEN_W-1:0]     len;
        logic                 neg_x;
        logic                 neg_y;
        logic                 norm;
        logic [LEN_W-1:0]     raw_x;
        logic [LEN_W-1:0]     raw_y;
    } mid_t;

    typedef struct packed {
        spring_t              pts;
        logic                 neg_x;
        logic                 neg_y;
        logic [PROD_W-1:0]    prod_x;
        logic [PROD_W-1:0]    prod_y;
    } mul_t;

    logic [NV-1:0]      vld_reg;
    logic               en;
    logic               load_out;
    logic               take_in;
    logic               out_valid_reg;
    result_t            out_data_reg;
    result_t            out_data_next;
    min_dist_t          min_distance_reg;

    spring_t            in_reg;
    spring_t            s1_reg;
    logic [2*COORD_W-1:0] sqx_reg;
    logic [2*COORD_W-1:0] sqy_reg;
    sqs_t               sq_head_reg;
    sqs_t               sq_st [SQ_STEPS+1];
    spring_t            sq_side_reg [SQ_STEPS+1];
    off_t               off_reg;
    off_t               off_next;
    dvs_t               dvx_head_reg;
    dvs_t               dvy_head_reg;
    dvs_t               dvx [DV_STEPS+1];
    dvs_t               dvy [DV_STEPS+1];
    mid_t               dv_side_reg [DV_STEPS+1];
    mid_t               mid_next;
    mul_t               mul_reg;
    mul_t               mul_next;

    logic [COORD_W:0]   dx_in;
    logic [COORD_W:0]   dy_in;
    logic [COORD_W:0]   dx_neg_in;
    logic [COORD_W:0]   dy_neg_in;
    logic [COORD_W-1:0] dxm_in;
    logic [COORD_W-1:0] dym_in;
    logic [COORD_W:0]   dx_o;
    logic [COORD_W:0]   dy_o;
    logic [COORD_W:0]   dx_o_neg;
    logic [COORD_W:0]   dy_o_neg;
    logic [LEN_W:0]     off_s;
    logic [LEN_W:0]     off_s_neg;
    logic [NUM_W-1:0]   num_x;
    logic [NUM_W-1:0]   num_y;
    logic [LEN_W-1:0]   mx;
    logic [LEN_W-1:0]   my;
    logic [LEN_W-1:0]   cx;
    logic [LEN_W-1:0]   cy;
    logic [SUM_W-1:0]   ax_w;
    logic [SUM_W-1:0]   ay_w;
    logic [SUM_W-1:0]   bx_w;
    logic [SUM_W-1:0]   by_w;
    logic [SUM_W-1:0]   cx_w;
    logic [SUM_W-1:0]   cy_w;
    logic               sq_rem_ok;
    logic               dv_rem_ok;

    // handshakes
    assign load_out     = !out_valid_reg || result.ready;
    assign en           = !vld_reg[NV-1] || load_out;
    assign take_in      = spring.valid && en;
    assign spring.ready = en;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            out_valid_reg    <= 1'b0;
            min_distance_reg <= MIN_DIST_RESET;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[NV-2:0], take_in};
            end
            if (load_out)
            begin
                out_valid_reg <= vld_reg[NV-1];
            end
            if (cfg.valid)
            begin
                min_distance_reg <= cfg.data;
            end
        end
    end

    // separation magnitudes for the squares
    always_comb
    begin
        dx_in     = {in_reg.second_x[COORD_W-1], in_reg.second_x}
                  - {in_reg.first_x[COORD_W-1], in_reg.first_x};
        dy_in     = {in_reg.second_y[COORD_W-1], in_reg.second_y}
                  - {in_reg.first_y[COORD_W-1], in_reg.first_y};
        dx_neg_in = '0 - dx_in;
        dy_neg_in = '0 - dy_in;
        dxm_in    = dx_in[COORD_W] ? dx_neg_in[COORD_W-1:0] : dx_in[COORD_W-1:0];
        dym_in    = dy_in[COORD_W] ? dy_neg_in[COORD_W-1:0] : dy_in[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg      <= spring.data;
            s1_reg      <= in_reg;
            sqx_reg     <= {{COORD_W{1'b0}}, dxm_in} * {{COORD_W{1'b0}}, dxm_in};
            sqy_reg     <= {{COORD_W{1'b0}}, dym_in} * {{COORD_W{1'b0}}, dym_in};
            sq_head_reg <= '{rad: RAD_W'(sqx_reg) + RAD_W'(sqy_reg), rem: '0, root: '0};
        end
    end

    // square root row
    assign sq_st[0] = sq_head_reg;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        sdc_sqrt_cell u_cell (
            .clk (clk),
            .en  (en),
            .cur (sq_st[k]),
            .nxt (sq_st[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= s1_reg;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // offset against the rest length, sign and magnitude split
    always_comb
    begin
        off_next.pts  = sq_side_reg[SQ_STEPS];
        off_next.len  = sq_st[SQ_STEPS].root;
        dx_o          = {off_next.pts.second_x[COORD_W-1], off_next.pts.second_x}
                      - {off_next.pts.first_x[COORD_W-1], off_next.pts.first_x};
        dy_o          = {off_next.pts.second_y[COORD_W-1], off_next.pts.second_y}
                      - {off_next.pts.first_y[COORD_W-1], off_next.pts.first_y};
        dx_o_neg      = '0 - dx_o;
        dy_o_neg      = '0 - dy_o;
        off_s         = (LEN_W+1)'(off_next.pts.rest_length) - {1'b0, off_next.len};
        off_s_neg     = '0 - off_s;
        off_next.off_neg = off_s[LEN_W];
        off_next.offm    = off_s[LEN_W] ? off_s_neg[LEN_W-1:0] : off_s[LEN_W-1:0];
        off_next.dx_neg  = dx_o[COORD_W];
        off_next.dy_neg  = dy_o[COORD_W];
        off_next.dxm     = dx_o[COORD_W] ? dx_o_neg[COORD_W-1:0] : dx_o[COORD_W-1:0];
        off_next.dym     = dy_o[COORD_W] ? dy_o_neg[COORD_W-1:0] : dy_o[COORD_W-1:0];
        off_next.norm    = off_next.len > LEN_W'(min_distance_reg);
    end

    // products d * offset, split into divider start state and raw path
    always_comb
    begin
        num_x          = NUM_W'(off_reg.dxm) * NUM_W'(off_reg.offm);
        num_y          = NUM_W'(off_reg.dym) * NUM_W'(off_reg.offm);
        mid_next.pts   = off_reg.pts;
        mid_next.len   = off_reg.len;
        mid_next.neg_x = off_reg.dx_neg ^ off_reg.off_neg;
        mid_next.neg_y = off_reg.dy_neg ^ off_reg.off_neg;
        mid_next.norm  = off_reg.norm;
        mid_next.raw_x = num_x[FRAC_W +: LEN_W];
        mid_next.raw_y = num_y[FRAC_W +: LEN_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            off_reg      <= off_next;
            dvx_head_reg <= '{rem: num_x[NUM_W-1 -: LEN_W], num_lo: num_x[LEN_W-1:0],
                              quot: '0};
            dvy_head_reg <= '{rem: num_y[NUM_W-1 -: LEN_W], num_lo: num_y[LEN_W-1:0],
                              quot: '0};
        end
    end

    // divider row, x and y lanes share the length
    assign dvx[0] = dvx_head_reg;
    assign dvy[0] = dvy_head_reg;

    for (genvar k = 0; k < DV_STEPS; k++)
    begin : g_div
        sdc_div_cell u_cell_x (
            .clk     (clk),
            .en      (en),
            .cur     (dvx[k]),
            .divisor (dv_side_reg[k].len),
            .nxt     (dvx[k+1])
        );
        sdc_div_cell u_cell_y (
            .clk     (clk),
            .en      (en),
            .cur     (dvy[k]),
            .divisor (dv_side_reg[k].len),
            .nxt     (dvy[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= mid_next;
            for (int k = 0; k < DV_STEPS; k++)
            begin
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // pick the quotient or the raw product, then stiffness scaling
    always_comb
    begin
        mx              = dv_side_reg[DV_STEPS].norm ? dvx[DV_STEPS].quot
                                                     : dv_side_reg[DV_STEPS].raw_x;
        my              = dv_side_reg[DV_STEPS].norm ? dvy[DV_STEPS].quot
                                                     : dv_side_reg[DV_STEPS].raw_y;
        mul_next.pts    = dv_side_reg[DV_STEPS].pts;
        mul_next.neg_x  = dv_side_reg[DV_STEPS].neg_x;
        mul_next.neg_y  = dv_side_reg[DV_STEPS].neg_y;
        mul_next.prod_x = PROD_W'(mx) * PROD_W'(dv_side_reg[DV_STEPS].pts.stiffness);
        mul_next.prod_y = PROD_W'(my) * PROD_W'(dv_side_reg[DV_STEPS].pts.stiffness);
    end

    // apply the correction, A moves against it and B with it
    always_comb
    begin
        cx   = mul_reg.prod_x[STIFF_SHIFT +: LEN_W];
        cy   = mul_reg.prod_y[STIFF_SHIFT +: LEN_W];
        cx_w = SUM_W'(cx);
        cy_w = SUM_W'(cy);
        ax_w = {{(SUM_W-COORD_W){mul_reg.pts.first_x[COORD_W-1]}}, mul_reg.pts.first_x};
        ay_w = {{(SUM_W-COORD_W){mul_reg.pts.first_y[COORD_W-1]}}, mul_reg.pts.first_y};
        bx_w = {{(SUM_W-COORD_W){mul_reg.pts.second_x[COORD_W-1]}}, mul_reg.pts.second_x};
        by_w = {{(SUM_W-COORD_W){mul_reg.pts.second_y[COORD_W-1]}}, mul_reg.pts.second_y};
        out_data_next.new_first_x  = sat32(mul_reg.neg_x ? ax_w + cx_w : ax_w - cx_w);
        out_data_next.new_first_y  = sat32(mul_reg.neg_y ? ay_w + cy_w : ay_w - cy_w);
        out_data_next.new_second_x = sat32(mul_reg.neg_x ? bx_w - cx_w : bx_w + cx_w);
        out_data_next.new_second_y = sat32(mul_reg.neg_y ? by_w - cy_w : by_w + cy_w);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg <= mul_next;
        end
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // checks
    assign sq_rem_ok = sq_st[SQ_STEPS].rem <= REM_W'({sq_st[SQ_STEPS].root, 1'b0});
    assign dv_rem_ok = !dv_side_reg[DV_STEPS].norm
                    || ((dvx[DV_STEPS].rem < dv_side_reg[DV_STEPS].len)
                     && (dvy[DV_STEPS].rem < dv_side_reg[DV_STEPS].len));

    `SDC_ASSERT_IMP(a_sqrt_rem, clk, rst_n, vld_reg[V_OFF-1], sq_rem_ok)
    `SDC_ASSERT_IMP(a_div_rem, clk, rst_n, vld_reg[V_MUL-1], dv_rem_ok)
    `SDC_ASSERT_NEXT(a_hold_row, clk, rst_n, !en, $stable(vld_reg))
    `SDC_ASSERT_IMP(a_no_drop, clk, rst_n, vld_reg[NV-1] && !load_out, !spring.ready)
endmodule

// File: tb/spring_distance_constraint_tb.sv
`timescale 1ns / 100ps

module spring_distance_constraint_tb;

    import sdc_pkg::*;

    localparam int LATENCY = 73;
    localparam int SETTLE  = LATENCY + 10;

    logic clk;
    logic rst_n;

    sdc_stream_if #(.payload_t(spring_t))   spring_ch ();
    sdc_stream_if #(.payload_t(result_t))   result_ch ();
    sdc_stream_if #(.payload_t(min_dist_t)) cfg_ch ();

    spring_distance_constraint DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .spring (spring_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    result_t   pending_positions[$];
    min_dist_t min_dist_copy;
    int        error_count;
    bit        quiet_mode;
    bit        hold_request;
    bit        hold_seen;
    int        hold_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [COORD_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic longint axis_correction(longint d, longint offset, logic [63:0] len,
                                               bit normalise, logic [STIFF_W-1:0] stiff);
        logic [127:0] prod;
        logic [127:0] scaled;
        logic [63:0]  m;
        prod = {64'd0, magnitude(d)} * {64'd0, magnitude(offset)};
        if (normalise)
            m = 64'(prod / {64'd0, len});
        else
            m = 64'(prod >> 16);
        scaled = {64'd0, m} * {111'd0, stiff};
        m = 64'(scaled >> STIFF_SHIFT);
        return ((d < 0) != (offset < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic result_t relax_spring(spring_t s);
        longint       ax;
        longint       ay;
        longint       bx;
        longint       by;
        longint       dx;
        longint       dy;
        longint       offset;
        longint       cx;
        longint       cy;
        logic [127:0] dist_sq;
        logic [127:0] trial;
        logic [63:0]  len;
        bit           normalise;
        result_t      r;
        ax = longint'(signed'(s.first_x));
        ay = longint'(signed'(s.first_y));
        bx = longint'(signed'(s.second_x));
        by = longint'(signed'(s.second_y));
        dx = bx - ax;
        dy = by - ay;
        dist_sq = {64'd0, magnitude(dx)} * {64'd0, magnitude(dx)}
                + {64'd0, magnitude(dy)} * {64'd0, magnitude(dy)};
        len = 0;
        for (int b = 33; b >= 0; b--)
        begin
            trial = {64'd0, len | (64'd1 << b)};
            if (trial * trial <= dist_sq)
                len = trial[63:0];
        end
        offset = longint'({33'd0, s.rest_length}) - longint'(len);
        normalise = len > {48'd0, min_dist_copy};
        cx = axis_correction(dx, offset, len, normalise, s.stiffness);
        cy = axis_correction(dy, offset, len, normalise, s.stiffness);
        r.new_first_x  = clamp32(ax - cx);
        r.new_first_y  = clamp32(ay - cy);
        r.new_second_x = clamp32(bx + cx);
        r.new_second_y = clamp32(by + cy);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s at %0t: got %h, expected %h", field, $time, got, want);
        error_count++;
    endtask

    // result side: ready pattern and the long hold-off
    always @(negedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen <= hold_request;
            hold_left <= 300;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (quiet_mode)
            result_ch.ready <= 1'b1;
        else
            result_ch.ready <= ($urandom_range(99) >= 30);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_positions.size() == 0)
            begin
                $display("unexpected result beat at %0t", $time);
                error_count++;
            end
            else
            begin
                want = pending_positions.pop_front();
                if (result_ch.data.new_first_x !== want.new_first_x)
                    report_mismatch("new_first_x", result_ch.data.new_first_x,
                                    want.new_first_x);
                if (result_ch.data.new_first_y !== want.new_first_y)
                    report_mismatch("new_first_y", result_ch.data.new_first_y,
                                    want.new_first_y);
                if (result_ch.data.new_second_x !== want.new_second_x)
                    report_mismatch("new_second_x", result_ch.data.new_second_x,
                                    want.new_second_x);
                if (result_ch.data.new_second_y !== want.new_second_y)
                    report_mismatch("new_second_y", result_ch.data.new_second_y,
                                    want.new_second_y);
            end
        end
    end

    task automatic send_spring(spring_t s);
        @(negedge clk);
        if (!quiet_mode && $urandom_range(99) < 30)
        begin
            spring_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        spring_ch.valid <= 1'b1;
        spring_ch.data  <= s;
        @(posedge clk);
        while (!spring_ch.ready)
            @(posedge clk);
        pending_positions.insert(pending_positions.size(), relax_spring(s));
    endtask

    task automatic drain_springs();
        @(negedge clk);
        spring_ch.valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_min_distance(min_dist_t value);
        drain_springs();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        min_dist_copy = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic spring_t make_spring(logic [31:0] ax, logic [31:0] ay,
                                            logic [31:0] bx, logic [31:0] by,
                                            logic [31:0] rest, logic [31:0] stiff);
        spring_t s;
        s.first_x     = ax;
        s.first_y     = ay;
        s.second_x    = bx;
        s.second_y    = by;
        s.rest_length = rest[REST_W-1:0];
        s.stiffness   = stiff[STIFF_W-1:0];
        return s;
    endfunction

    function automatic spring_t random_spring();
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] span;
        int          kind;
        kind = $urandom_range(9);
        ax = $urandom;
        ay = $urandom;
        case (kind)
            0, 1, 2:
                return make_spring(ax, ay, $urandom, $urandom, $urandom, $urandom_range(131071));
            3, 4, 5:
            begin
                // moderate springs with rest length of the same order as the separation
                ax = 32'(signed'(ax) >>> 8);
                ay = 32'(signed'(ay) >>> 8);
                span = $urandom_range(1, 1 << 20);
                return make_spring(ax, ay, ax + span - $urandom_range(0, 2 * span),
                                   ay + $urandom_range(0, span) - span / 2,
                                   $urandom_range(0, 3 * span), $urandom_range(131071));
            end
            6, 7:
                // short separations around the normalising threshold
                return make_spring(ax, ay, ax + $urandom_range(0, 16) - 8,
                                   ay + $urandom_range(0, 16) - 8,
                                   $urandom, $urandom_range(131071));
            8:
                return make_spring(ax, ay, ax, ay, $urandom, $urandom_range(131071));
            default:
                return make_spring($urandom_range(1) ? 32'h80000000 : 32'h7fffffff,
                                   $urandom_range(1) ? 32'h80000000 : 32'h7fffffff,
                                   $urandom_range(1) ? 32'h80000000 : 32'h7fffffff,
                                   $urandom_range(1) ? 32'h80000000 : 32'h7fffffff,
                                   $urandom_range(1) ? 32'h7fffffff : 32'd0,
                                   $urandom_range(1) ? 32'h1ffff : 32'd65536);
        endcase
    endfunction

    task automatic test_directed();
        send_spring(make_spring(0, 0, 32'h00010000, 0, 32'h00020000, 65536));
        send_spring(make_spring(0, 0, 0, 32'h00030000, 32'h00010000, 65536));
        send_spring(make_spring(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                32'h7fffffff, 32'h1ffff));
        send_spring(make_spring(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                                0, 32'h1ffff));
        send_spring(make_spring(32'h80000000, 0, 32'h7fffffff, 0, 0, 65536));
        send_spring(make_spring(0, 32'h7fffffff, 0, 32'h80000000, 32'h7fffffff, 65536));
        send_spring(make_spring(32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef0,
                                32'h7fffffff, 32'h1ffff));
        // separation exactly at the threshold stays raw, one above normalises
        send_spring(make_spring(100, 200, 103, 200, 32'h7fffffff, 65536));
        send_spring(make_spring(100, 200, 104, 200, 32'h7fffffff, 65536));
        send_spring(make_spring(-5, -5, -2, -5, 1000, 65536));
        send_spring(make_spring(0, 0, 32'h00050000, 32'h000c0000, 32'h000d0000, 65536));
        send_spring(make_spring(0, 0, 32'h00050000, 32'h000c0000, 0, 0));
        send_spring(make_spring(32'hffff0000, 32'h00010000, 32'h00010000, 32'hffff0000,
                                32'h00008000, 32'h1ffff));
        send_spring(make_spring(32'h7fffffff, 0, 32'h7ffffff0, 0, 32'h7fffffff, 32'h1ffff));
        send_spring(make_spring(32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa,
                                32'h2aaaaaaa, 32'h15555));
        send_spring(make_spring(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
                                32'h55555555, 32'h0aaaa));
        send_spring(make_spring(1, 1, 0, 0, 32'h7fffffff, 1));
    endtask

    task automatic test_random(min_dist_t setting, int count);
        write_min_distance(setting);
        for (int i = 0; i < count; i++)
        begin
            // a stretch with no idling in the middle of each phase
            quiet_mode = (i >= count / 3) && (i < count / 2);
            send_spring(random_spring());
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_request = !hold_request;
        for (int i = 0; i < 100; i++)
            send_spring(random_spring());
    endtask

    initial
    begin
        rst_n           = 1'b0;
        error_count     = 0;
        quiet_mode      = 1'b0;
        hold_request    = 1'b0;
        hold_seen       = 1'b0;
        hold_left       = 0;
        min_dist_copy   = MIN_DIST_RESET;
        spring_ch.valid = 1'b0;
        spring_ch.data  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        result_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(16'd0, 90);
        test_random(16'hffff, 90);
        test_random(16'd1, 70);
        test_random(16'($urandom), 70);
        test_backpressure();
        test_random(MIN_DIST_RESET, 20);
        drain_springs();

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sdc_pkg.sv
rtl/sdc_stream_if.sv
rtl/sdc_sqrt_cell.sv
rtl/sdc_div_cell.sv
rtl/spring_distance_constraint.sv
tb/spring_distance_constraint_tb.sv
